/* src/tcg_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the text cursor glyph renderer.
// No dependencies; every other file of the block imports this package.
package tcg_pkg;

	localparam int MAX_ROWS_OUT = 16;
	localparam int ROW_W        = 4;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = 1;
	localparam int QCNT_W       = 2;
	localparam int CFG_DATA_W   = 10;

	localparam logic        ACT_LOAD     = 1'b1;
	localparam logic [7:0]  CODE_TAB     = 8'd9;
	localparam logic [7:0]  CODE_NEWLINE = 8'd10;
	localparam logic [7:0]  CODE_RETURN  = 8'd13;
	localparam logic [9:0]  LINE_MAX     = 10'd1023;
	localparam logic [3:0]  WRAP_MARGIN  = 4'd6;
	localparam logic [3:0]  GLYPH_WIDTH  = 4'd8;

	typedef enum logic [1:0] {
		CFG_TEXT_COLOR    = 2'd0,
		CFG_SCREEN_WIDTH  = 2'd1,
		CFG_SCREEN_HEIGHT = 2'd2,
		CFG_TAB_SPACE     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [3:0] text_color;
		logic [9:0] screen_width;
		logic [8:0] screen_height;
		logic [7:0] tab_space;
	} cfg_t;

	// One word of work for the back part: a font row write or a glyph render.
	typedef struct packed {
		logic       is_load;
		logic [7:0] code;
		logic [3:0] row;
		logic [7:0] bits;
		logic [9:0] col;
		logic [9:0] line;
	} cmd_t;

endpackage

/* src/text_cursor_glyph_renderer.sv */
`timescale 1ns / 1ps
// 8x16 text-mode character generator with a text cursor. Font-load words write one
// row of the font RAM; render words either move the cursor (newline, tab; return is
// ignored) or draw a glyph as min(GLYPH_ROWS,16) row words of eight 4-bit pixels plus an
// on-screen mask, then advance the cursor. A character occupies the font RAM read port
// for one read per row; a font load takes a single write and control codes none. Input
// words are taken every cycle while the two-entry command queue has room, and with the
// queue empty a character is written into the queue, read from the font RAM and then
// held in the output register, where its first row is offered. Font rows read before
// they are loaded return arbitrary data. Depends on tcg_pkg and the
// tcg_front, tcg_queue and tcg_back modules.
module text_cursor_glyph_renderer import tcg_pkg::*; #(
	parameter int GLYPH_ROWS = 16,
	parameter int CHAR_COUNT = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  action,
	input  logic [7:0]            glyph_code,
	input  logic [3:0]            glyph_row,
	input  logic [7:0]            glyph_bits,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [9:0]            row_x,
	output logic [9:0]            row_y,
	output logic [31:0]           pixels,
	output logic [7:0]            pixel_mask,
	output logic                  last
);

	cfg_t cfg_q;
	logic push, pop, q_full, head_valid;
	cmd_t push_cmd, head_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_color    <= 4'd15;
			cfg_q.screen_width  <= 10'd640;
			cfg_q.screen_height <= 9'd480;
			cfg_q.tab_space     <= 8'd4;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_TEXT_COLOR:    cfg_q.text_color    <= cfg_data[3:0];
				CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[9:0];
				CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[8:0];
				CFG_TAB_SPACE:     cfg_q.tab_space     <= cfg_data[7:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	tcg_front #(
		.GLYPH_ROWS(GLYPH_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.glyph_code (glyph_code),
		.glyph_row  (glyph_row),
		.glyph_bits (glyph_bits),
		.cfg        (cfg_q),
		.q_full     (q_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	tcg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	tcg_back #(
		.GLYPH_ROWS(GLYPH_ROWS),
		.CHAR_COUNT(CHAR_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.cfg        (cfg_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_x      (row_x),
		.row_y      (row_y),
		.pixels     (pixels),
		.pixel_mask (pixel_mask),
		.last       (last)
	);

`ifndef NO_ASSERTIONS
	a_printable_queued: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action != ACT_LOAD && glyph_code != CODE_NEWLINE &&
		glyph_code != CODE_RETURN && glyph_code != CODE_TAB |=> head_valid)
		else $error("printable character not queued");

	a_row_same_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> !out_valid || row_x == $past(row_x))
		else $error("glyph row moved in x within one glyph");

	a_row_next_y: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> !out_valid || row_y == $past(row_y) + 10'd1)
		else $error("glyph rows not consecutive");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("command queue popped while empty");
`endif

endmodule

/* src/tcg_front.sv */
`timescale 1ns / 1ps
// Front part: accepts input words, keeps the text cursor, handles control codes
// and pushes font loads and printable characters into the command queue. Uses tcg_pkg.
module tcg_front import tcg_pkg::*; #(
	parameter int GLYPH_ROWS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic [7:0] glyph_code,
	input  logic [3:0] glyph_row,
	input  logic [7:0] glyph_bits,
	input  cfg_t       cfg,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);

	logic [9:0]  col_q, line_q;
	logic [9:0]  col_d, line_d;
	logic        accept, is_load, is_nl, is_cr, is_tab, printable, wrap;
	logic [10:0] line_step, tab_nx, chr_nx;
	logic [9:0]  line_sat;

	assign in_stall = q_full;

	always_comb begin
		accept    = in_valid && !in_stall;
		is_load   = (action == ACT_LOAD);
		is_nl     = (glyph_code == CODE_NEWLINE);
		is_cr     = (glyph_code == CODE_RETURN);
		is_tab    = (glyph_code == CODE_TAB);
		printable = !is_load && !is_nl && !is_cr && !is_tab;
		push      = accept && (is_load || printable);

		push_cmd.is_load = is_load;
		push_cmd.code    = glyph_code;
		push_cmd.row     = glyph_row;
		push_cmd.bits    = glyph_bits;
		push_cmd.col     = col_q;
		push_cmd.line    = line_q;

		line_step = {1'b0, line_q} + 11'(GLYPH_ROWS);
		line_sat  = (line_step > {1'b0, LINE_MAX}) ? LINE_MAX : line_step[9:0];
		tab_nx    = {1'b0, col_q} + {3'b0, cfg.tab_space};
		chr_nx    = {1'b0, col_q} + {7'b0, GLYPH_WIDTH};
		wrap      = ({1'b0, chr_nx} + {8'b0, WRAP_MARGIN}) > {2'b0, cfg.screen_width};

		col_d  = col_q;
		line_d = line_q;
		if (accept && !is_load) begin
			if (is_nl) begin
				col_d  = '0;
				line_d = line_sat;
			end else if (is_tab) begin
				if (tab_nx < {1'b0, cfg.screen_width})
					col_d = tab_nx[9:0];
			end else if (printable) begin
				if (wrap) begin
					col_d  = '0;
					line_d = line_sat;
				end else begin
					col_d = chr_nx[9:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			line_q <= '0;
		end else begin
			col_q  <= col_d;
			line_q <= line_d;
		end
	end

endmodule

/* src/tcg_queue.sv */
`timescale 1ns / 1ps
// Two-entry command queue between the front and back parts.
// Uses tcg_pkg for the command word type and depth constants.
module tcg_queue import tcg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* src/tcg_back.sv */
`timescale 1ns / 1ps
// Back part: holds the font RAM, writes font rows and walks glyph rows into
// a two-stage pipeline: the font read stage and the pixel output register. Uses tcg_pkg.
module tcg_back import tcg_pkg::*; #(
	parameter int GLYPH_ROWS = 16,
	parameter int CHAR_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  cmd_t        head_cmd,
	output logic        pop,
	input  cfg_t        cfg,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [9:0]  row_x,
	output logic [9:0]  row_y,
	output logic [31:0] pixels,
	output logic [7:0]  pixel_mask,
	output logic        last
);

	localparam int DEPTH    = CHAR_COUNT * GLYPH_ROWS;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int ROWS_OUT = (GLYPH_ROWS < MAX_ROWS_OUT) ? GLYPH_ROWS : MAX_ROWS_OUT;

	logic [7:0]       font_mem [DEPTH];
	logic [ROW_W-1:0] row_q;

	logic             adv, issue, last_row, code_ok, row_ok, we;
	logic [ADDR_W-1:0] base_addr, raddr, waddr;
	logic [10:0]      line_w;
	logic [7:0]       mask_w;

	logic             v_s1, last_s1, blank_s1;
	logic [9:0]       x_s1, y_s1;
	logic [7:0]       mask_s1, rdata_s1;
	logic [31:0]      pix_w;
	logic [7:0]       bits_w;

	always_comb begin
		adv      = !out_valid || !out_stall;
		code_ok  = ({1'b0, head_cmd.code} < 9'(CHAR_COUNT));
		row_ok   = ({2'b0, head_cmd.row} < 6'(GLYPH_ROWS));
		issue    = head_valid && !head_cmd.is_load && adv;
		last_row = (row_q == ROW_W'(ROWS_OUT - 1));
		we       = head_valid && head_cmd.is_load && code_ok && row_ok;
		pop      = (head_valid && head_cmd.is_load) || (issue && last_row);

		base_addr = ADDR_W'(head_cmd.code) * ADDR_W'(GLYPH_ROWS);
		waddr     = base_addr + ADDR_W'(head_cmd.row);
		raddr     = code_ok ? (base_addr + ADDR_W'(row_q)) : '0;

		line_w = {1'b0, head_cmd.line} + {7'b0, row_q};
		for (int k = 0; k < 8; k++)
			mask_w[k] = (({1'b0, head_cmd.col} + 11'(k)) < {1'b0, cfg.screen_width}) &&
			            (line_w < {2'b0, cfg.screen_height});

		bits_w = blank_s1 ? 8'h00 : rdata_s1;
		for (int k = 0; k < 8; k++)
			pix_w[4*k +: 4] = (mask_s1[k] && bits_w[7-k]) ? cfg.text_color : 4'h0;
	end

	always_ff @(posedge clk) begin
		if (we)
			font_mem[waddr] <= head_cmd.bits;
		if (adv)
			rdata_s1 <= font_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1       <= head_cmd.col;
			y_s1       <= line_w[9:0];
			mask_s1    <= mask_w;
			last_s1    <= last_row;
			blank_s1   <= !code_ok;
			row_x      <= x_s1;
			row_y      <= y_s1;
			pixels     <= pix_w;
			pixel_mask <= mask_s1;
			last       <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (issue)
				row_q <= last_row ? '0 : row_q + 1'b1;
			if (adv) begin
				v_s1      <= issue;
				out_valid <= v_s1;
			end
		end
	end

endmodule
